[hw/rtl/u128alu_pkg.sv]
// Package for the 128-bit multiply/divide/shift unit: widths, mode and state codes,
// and the control/status structs passed between sequencer and datapath.
// No dependencies.
package u128alu_pkg;

    localparam int unsigned HalfW = 64;
    localparam int unsigned FullW = 128;
    localparam int unsigned CntW  = 7;
    localparam int unsigned ModeW = 3;
    localparam int unsigned ShW   = 8;

    typedef logic [FullW-1:0] t_word;

    typedef enum logic [ModeW-1:0] {
        MODE_MUL = 3'd0,
        MODE_DIV = 3'd1,
        MODE_MOD = 3'd2,
        MODE_SHL = 3'd3,
        MODE_SHR = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_dp_ctl;

    typedef struct packed {
        logic iter;
    } t_dp_stat;

endpackage

[hw/rtl/u128alu_if.sv]
// Handshake interfaces for the input and result channels of the 128-bit ALU.
// Depends on u128alu_pkg.
interface u128alu_in_if;
    logic                            valid;
    logic                            ready;
    logic [u128alu_pkg::ModeW-1:0]   mode;
    logic [u128alu_pkg::HalfW-1:0]   a_hi;
    logic [u128alu_pkg::HalfW-1:0]   a_lo;
    logic [u128alu_pkg::HalfW-1:0]   b_hi;
    logic [u128alu_pkg::HalfW-1:0]   b_lo;
    logic [u128alu_pkg::ShW-1:0]     shift_amount;

    modport source (output valid, mode, a_hi, a_lo, b_hi, b_lo, shift_amount, input ready);
    modport sink   (input valid, mode, a_hi, a_lo, b_hi, b_lo, shift_amount, output ready);
endinterface

interface u128alu_out_if;
    logic                            valid;
    logic                            ready;
    logic [u128alu_pkg::HalfW-1:0]   result_hi;
    logic [u128alu_pkg::HalfW-1:0]   result_lo;
    logic                            divide_by_zero;

    modport source (output valid, result_hi, result_lo, divide_by_zero, input ready);
    modport sink   (input valid, result_hi, result_lo, divide_by_zero, output ready);
endinterface

[hw/rtl/u128alu_dp.sv]
// Datapath: operand registers, one shared 129-bit add/subtract unit used per bit step
// for shift-add multiply and restoring division, barrel shift, result register.
// Depends on u128alu_pkg.
module u128alu_dp (
    input  logic                           i_clk,
    input  logic [u128alu_pkg::ModeW-1:0]  i_mode,
    input  u128alu_pkg::t_word             i_a,
    input  u128alu_pkg::t_word             i_b,
    input  logic [u128alu_pkg::ShW-1:0]    i_shamt,
    input  u128alu_pkg::t_dp_ctl           i_ctl,
    output u128alu_pkg::t_dp_stat          o_stat,
    output u128alu_pkg::t_word             o_res,
    output logic                           o_dz
);

    logic [u128alu_pkg::ModeW-1:0] r_mode;
    u128alu_pkg::t_word            r_acc;
    u128alu_pkg::t_word            r_x;
    u128alu_pkg::t_word            r_y;
    u128alu_pkg::t_word            r_res;
    logic                          r_dz;

    logic [u128alu_pkg::FullW:0]   add_x;
    logic [u128alu_pkg::FullW:0]   add_y;
    logic                          add_cin;
    logic [u128alu_pkg::FullW+1:0] add_sum;
    logic                          fits;
    logic                          b_zero;
    logic                          in_div;
    u128alu_pkg::t_word            shl_res;
    u128alu_pkg::t_word            shr_res;
    u128alu_pkg::t_word            load_res;

    assign b_zero = ~|i_b;
    assign in_div = (i_mode == u128alu_pkg::MODE_DIV) || (i_mode == u128alu_pkg::MODE_MOD);
    assign o_stat.iter = (i_mode == u128alu_pkg::MODE_MUL) || (in_div && !b_zero);

    // shared adder: acc + multiplicand, or {rem, next dividend bit} - divisor
    always_comb begin
        if (r_mode == u128alu_pkg::MODE_MUL) begin
            add_x   = {1'b0, r_acc};
            add_y   = {1'b0, r_x};
            add_cin = 1'b0;
        end else begin
            add_x   = {r_acc, r_x[u128alu_pkg::FullW-1]};
            add_y   = ~{1'b0, r_y};
            add_cin = 1'b1;
        end
        add_sum = {1'b0, add_x} + {1'b0, add_y}
                  + {{(u128alu_pkg::FullW+1){1'b0}}, add_cin};
    end

    assign fits = add_sum[u128alu_pkg::FullW+1];

    assign shl_res = i_shamt[u128alu_pkg::ShW-1] ? '0 : (i_a << i_shamt[u128alu_pkg::CntW-1:0]);
    assign shr_res = i_shamt[u128alu_pkg::ShW-1] ? '0 : (i_a >> i_shamt[u128alu_pkg::CntW-1:0]);

    always_comb begin
        unique case (u128alu_pkg::t_mode'(i_mode))
            u128alu_pkg::MODE_SHL: load_res = shl_res;
            u128alu_pkg::MODE_SHR: load_res = shr_res;
            default:               load_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mode <= i_mode;
            r_acc  <= '0;
            r_x    <= i_a;
            r_y    <= i_b;
            r_res  <= load_res;
            r_dz   <= in_div && b_zero;
        end else if (i_ctl.step) begin
            if (r_mode == u128alu_pkg::MODE_MUL) begin
                if (r_y[0]) begin
                    r_acc <= add_sum[u128alu_pkg::FullW-1:0];
                end
                r_x <= {r_x[u128alu_pkg::FullW-2:0], 1'b0};
                r_y <= {1'b0, r_y[u128alu_pkg::FullW-1:1]};
            end else begin
                r_acc <= fits ? add_sum[u128alu_pkg::FullW-1:0] : add_x[u128alu_pkg::FullW-1:0];
                r_x   <= {r_x[u128alu_pkg::FullW-2:0], fits};
            end
        end else if (i_ctl.finish) begin
            r_res <= (r_mode == u128alu_pkg::MODE_DIV) ? r_x : r_acc;
        end
    end

    assign o_res = r_res;
    assign o_dz  = r_dz;

endmodule

[hw/rtl/u128alu_ctrl.sv]
// Sequencer: accepts one transaction, runs 128 bit steps of the datapath when needed,
// holds the result until taken. Depends on u128alu_pkg.
module u128alu_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_out_ready,
    input  u128alu_pkg::t_dp_stat   i_stat,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    output u128alu_pkg::t_dp_ctl    o_ctl
);

    u128alu_pkg::t_state           r_state;
    u128alu_pkg::t_state           n_state;
    logic [u128alu_pkg::CntW-1:0]  r_cnt;
    logic [u128alu_pkg::CntW-1:0]  n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= u128alu_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_ctl       = '0;
        unique case (r_state)
            u128alu_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = i_stat.iter ? u128alu_pkg::ST_RUN : u128alu_pkg::ST_DONE;
                end
            end
            u128alu_pkg::ST_RUN: begin
                o_ctl.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (&r_cnt) begin
                    n_state = u128alu_pkg::ST_FIN;
                end
            end
            u128alu_pkg::ST_FIN: begin
                o_ctl.finish = 1'b1;
                n_state      = u128alu_pkg::ST_DONE;
            end
            u128alu_pkg::ST_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = u128alu_pkg::ST_IDLE;
                end
            end
            default: n_state = u128alu_pkg::ST_IDLE;
        endcase
    end

endmodule

[hw/rtl/uint128_mul_div_shift_alu.sv]
// 128-bit unsigned ALU: multiply mod 2^128, quotient, remainder, logical shifts.
// Multiply, divide, modulo: load, then 128 bit steps through the shared 129-bit adder,
// then result write (a divide by zero skips these); others: result valid the next cycle.
// One transaction at a time; next accept the cycle after the result is taken, and a
// pending result is held while the sink stalls.
// Synchronous active-low reset returns the sequencer to idle with no result pending.
module uint128_mul_div_shift_alu (
    input  logic           i_clk,
    input  logic           i_rst_n,
    u128alu_in_if.sink     i_in,
    u128alu_out_if.source  o_out
);

    u128alu_pkg::t_dp_ctl  ctl;
    u128alu_pkg::t_dp_stat stat;
    u128alu_pkg::t_word    res;
    logic                  dz;
    logic                  in_ready;
    logic                  out_valid;

    u128alu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_ctl       (ctl)
    );

    u128alu_dp u_dp (
        .i_clk   (i_clk),
        .i_mode  (i_in.mode),
        .i_a     ({i_in.a_hi, i_in.a_lo}),
        .i_b     ({i_in.b_hi, i_in.b_lo}),
        .i_shamt (i_in.shift_amount),
        .i_ctl   (ctl),
        .o_stat  (stat),
        .o_res   (res),
        .o_dz    (dz)
    );

    assign i_in.ready           = in_ready;
    assign o_out.valid          = out_valid;
    assign o_out.result_hi      = res[u128alu_pkg::FullW-1:u128alu_pkg::HalfW];
    assign o_out.result_lo      = res[u128alu_pkg::HalfW-1:0];
    assign o_out.divide_by_zero = dz;

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is pending");

    a_dz_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && dz) |-> (res == '0))
        else $error("divide by zero with nonzero result");

    a_ready_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && o_out.ready) |=> in_ready)
        else $error("not ready after result taken");

    a_no_ctl_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({ctl.load, ctl.step, ctl.finish}))
        else $error("datapath controls overlap");
`endif

endmodule
